// ===== hw/rtl/dnb_pkg.sv =====
// Shared types and constants for the direct N-body acceleration block.
package dnb_pkg;

  localparam int CoordW = 24;
  localparam int SlotW  = 12;
  localparam int CountW = 13;
  localparam int CfgW   = 24;
  localparam int AccW   = 48;
  localparam int KW     = 48;
  localparam int R2W    = 50;
  localparam int RootW  = 31;
  localparam int RemW   = 33;
  localparam int DenW   = 81;
  localparam int QuoW   = 47;
  localparam int SumW   = 61;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_SOFT  = 1'b1;

  localparam logic [CountW-1:0] COUNT_RESET = 13'd4096;
  localparam logic [CfgW-1:0]   SOFT_RESET  = 24'd1099512;

  localparam logic [SumW-1:0] TERM_LIM = {{(SumW-48){1'b0}}, 1'b1, 47'd0};
  localparam logic [SumW-1:0] ACC_HI   = {{(SumW-47){1'b0}}, {47{1'b1}}};
  localparam logic [SumW-1:0] ACC_LO   = {{(SumW-47){1'b1}}, 47'd0};

  typedef struct packed {
    logic [2:0][CoordW-1:0] pos;
    logic [CoordW-1:0]      mass;
  } particle_t;

  typedef struct packed {
    logic               on;
    logic               last;
    logic [2:0]         neg;
    logic [2:0]         nz;
    logic [2:0][KW-1:0] k;
  } pair_tag_t;

  typedef struct packed {
    pair_tag_t        tag;
    logic [R2W-1:0]   r2;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_state_t;

  typedef struct packed {
    logic       on;
    logic       last;
    logic [2:0] neg;
    logic [2:0] nz;
    logic [2:0] sat;
  } div_tag_t;

  typedef struct packed {
    div_tag_t             tag;
    logic [DenW-1:0]      den;
    logic [2:0][DenW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
  } div_state_t;

endpackage

// ===== hw/rtl/dnb_if.sv =====
// Request and response channel interfaces.
interface dnb_req_if;
  import dnb_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SlotW-1:0]  slot;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [CoordW-1:0] pos_z;
  logic [CoordW-1:0] mass;
  modport source (output valid, operation, slot, pos_x, pos_y, pos_z, mass, input ready);
  modport sink (input valid, operation, slot, pos_x, pos_y, pos_z, mass, output ready);
endinterface

interface dnb_rsp_if;
  import dnb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [AccW-1:0] acc_x;
  logic signed [AccW-1:0] acc_y;
  logic signed [AccW-1:0] acc_z;
  logic                   saturated;
  modport source (output valid, acc_x, acc_y, acc_z, saturated, input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, saturated, output ready);
endinterface

// ===== hw/rtl/dnb_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module dnb_sqrt_cell #(
  parameter int Idx = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  dnb_pkg::sqrt_state_t in_st,
  output logic                 out_vld,
  output dnb_pkg::sqrt_state_t out_st
);
  import dnb_pkg::*;

  localparam int Pos = 2 * (RootW - 1 - Idx);

  logic [R2W+11:0] v;
  logic [RemW+1:0] rem_sh;
  logic [RemW+1:0] trial;
  sqrt_state_t     st_next;

  always_comb begin
    v       = {in_st.r2, 12'd0};
    rem_sh  = {in_st.rem, v[Pos+1 -: 2]};
    trial   = {2'b00, in_st.root, 2'b01};
    st_next = in_st;
    if (rem_sh >= trial) begin
      st_next.rem  = RemW'(rem_sh - trial);
      st_next.root = {in_st.root[RootW-2:0], 1'b1};
    end else begin
      st_next.rem  = RemW'(rem_sh);
      st_next.root = {in_st.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_st <= st_next;
  end

endmodule

// ===== hw/rtl/dnb_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider, three lanes.
module dnb_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  dnb_pkg::div_state_t in_st,
  output logic                out_vld,
  output dnb_pkg::div_state_t out_st
);
  import dnb_pkg::*;

  logic [2:0][DenW:0] sh;
  div_state_t         st_next;

  always_comb begin
    st_next = in_st;
    for (int a = 0; a < 3; a++) begin
      sh[a] = {in_st.rem[a], 1'b0};
      if (sh[a] >= {1'b0, in_st.den}) begin
        st_next.rem[a] = DenW'(sh[a] - {1'b0, in_st.den});
        st_next.quo[a] = {in_st.quo[a][QuoW-2:0], 1'b1};
      end else begin
        st_next.rem[a] = DenW'(sh[a]);
        st_next.quo[a] = {in_st.quo[a][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_st <= st_next;
  end

endmodule

// ===== hw/rtl/direct_nbody_acceleration.sv =====
// Direct-summation softened gravity: particle store, pair pipeline and accumulator.
// A load request writes one particle slot. An evaluate request reads the named
// slot, then streams stored particles 0..n-1 (n is particle_count capped at
// MAX_PARTICLES) through the pair pipeline at one particle per cycle (difference,
// squares, a 31-cell square root chain, the denominator product and a 47-cell
// divider chain per axis), reading them from the memory's single read port. The
// result waits in an output register; loads are taken while it waits. Slot memory
// has no reset.
module direct_nbody_acceleration #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [dnb_pkg::CfgW-1:0] cfg_data,
  dnb_req_if.sink                  req,
  dnb_rsp_if.source                rsp
);
  import dnb_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_STREAM = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [CountW-1:0] particle_count;
  logic [CfgW-1:0]   softening_sq;

  logic [2:0]        state;
  logic [SlotW-1:0]  slot_q;
  logic [AW-1:0]     j;
  particle_t         pi;

  particle_t         mem [MAX_PARTICLES];
  particle_t         rd_data;
  particle_t         wr_word;
  logic [AW-1:0]     rd_addr;

  logic              req_acc;
  logic              in_slot_ok;
  logic              slot_ok;
  logic [31:0]       n_eff;
  logic [AW-1:0]     last_idx;

  // issue and front stages
  logic              s0_vld, s0_on, s0_last;
  logic              a_vld, a_on, a_last;
  logic [2:0]        a_neg, a_nz;
  logic [2:0][CoordW-1:0] a_mag;
  logic [CoordW-1:0] a_m;
  logic              b_vld, b_on, b_last;
  logic [2:0]        b_neg, b_nz;
  logic [2:0][KW-1:0] b_sq, b_k;
  logic [R2W-1:0]    r2_sum;
  sqrt_state_t       c_st;

  logic [RootW:0]    sq_vld;
  sqrt_state_t       sq_st [RootW+1];

  logic              m1_vld;
  pair_tag_t         m1_tag;
  logic [55:0]       m1_lo, m1_hi;
  logic              m2_vld;
  pair_tag_t         m2_tag;
  logic [DenW-1:0]   m2_den;
  logic [2:0][58:0]  ks;
  div_state_t        p_st;

  logic [QuoW:0]     dv_vld;
  div_state_t        dv_st [QuoW+1];

  logic [2:0][SumW-1:0] acc;
  logic [2:0][SumW-1:0] term;
  logic              sat_acc;
  logic              done_q;

  logic              rsp_vld;
  logic [2:0][AccW-1:0] out_acc;
  logic              out_sat;
  logic [2:0][AccW-1:0] clamp_acc;
  logic              clamp_sat;

  assign req_acc    = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign in_slot_ok = 32'(req.slot) < 32'(MAX_PARTICLES);
  assign slot_ok    = 32'(slot_q) < 32'(MAX_PARTICLES);
  assign n_eff      = (32'(particle_count) > 32'(MAX_PARTICLES)) ? 32'(MAX_PARTICLES)
                                                                   : 32'(particle_count);
  assign last_idx   = (n_eff == 32'd0) ? '0 : AW'(n_eff - 32'd1);
  assign rd_addr    = (state == S_STREAM) ? j : AW'(req.slot);

  always_comb begin
    wr_word.pos[0] = req.pos_x;
    wr_word.pos[1] = req.pos_y;
    wr_word.pos[2] = req.pos_z;
    wr_word.mass   = req.mass;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= COUNT_RESET;
      softening_sq   <= SOFT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUNT: particle_count <= cfg_data[CountW-1:0];
        REG_SOFT:  softening_sq   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // particle memory
  always_ff @(posedge clk) begin
    if (req_acc && req.operation == OP_LOAD && in_slot_ok) begin
      mem[AW'(req.slot)] <= wr_word;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= (state == S_STREAM);
      case (state)
        S_IDLE: begin
          if (req_acc && req.operation == OP_EVAL) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_STREAM;
        S_STREAM: begin
          if (j == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done_q) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp_vld || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (state == S_IDLE && req_acc) begin
      slot_q <= req.slot;
    end
    if (state == S_FETCH) begin
      pi <= rd_data;
      j  <= '0;
    end else if (state == S_STREAM) begin
      j <= j + AW'(1);
    end
    s0_on   <= slot_ok && (32'(j) < n_eff) && (32'(j) != 32'(slot_q));
    s0_last <= (j == last_idx);
  end

  // difference and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= s0_vld;
    end
    a_on   <= s0_on;
    a_last <= s0_last;
    a_m    <= rd_data.mass;
    for (int a = 0; a < 3; a++) begin
      a_neg[a] <= pi.pos[a] < rd_data.pos[a];
      a_nz[a]  <= pi.pos[a] != rd_data.pos[a];
      a_mag[a] <= (pi.pos[a] < rd_data.pos[a]) ? rd_data.pos[a] - pi.pos[a]
                                               : pi.pos[a] - rd_data.pos[a];
    end
  end

  // squares and mass products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_on   <= a_on;
    b_last <= a_last;
    b_neg  <= a_neg;
    b_nz   <= a_nz;
    for (int a = 0; a < 3; a++) begin
      b_sq[a] <= KW'(a_mag[a]) * KW'(a_mag[a]);
      b_k[a]  <= KW'(a_m) * KW'(a_mag[a]);
    end
  end

  assign r2_sum = R2W'(b_sq[0]) + R2W'(b_sq[1]) + R2W'(b_sq[2])
                + R2W'({softening_sq, 8'd0});

  // softened squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= b_vld;
    end
    c_st.tag.on   <= b_on && (r2_sum != '0);
    c_st.tag.last <= b_last;
    c_st.tag.neg  <= b_neg;
    c_st.tag.nz   <= b_nz;
    c_st.tag.k    <= b_k;
    c_st.r2       <= r2_sum;
    c_st.rem      <= '0;
    c_st.root     <= '0;
  end

  assign sq_st[0] = c_st;

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    dnb_sqrt_cell #(.Idx(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (sq_vld[g]),
      .in_st   (sq_st[g]),
      .out_vld (sq_vld[g+1]),
      .out_st  (sq_st[g+1])
    );
  end

  // denominator r2 * root in two partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      dv_vld[0] <= 1'b0;
    end else begin
      m1_vld <= sq_vld[RootW];
      m2_vld <= m1_vld;
      dv_vld[0] <= m2_vld;
    end
    m1_tag <= sq_st[RootW].tag;
    m1_lo  <= 56'(sq_st[RootW].r2[24:0]) * 56'(sq_st[RootW].root);
    m1_hi  <= 56'(sq_st[RootW].r2[R2W-1:25]) * 56'(sq_st[RootW].root);
    m2_tag <= m1_tag;
    m2_den <= {m1_hi, 25'd0} + DenW'(m1_lo);
    p_st.quo      <= '0;
    p_st.tag.on   <= m2_tag.on;
    p_st.tag.last <= m2_tag.last;
    p_st.tag.neg  <= m2_tag.neg;
    p_st.tag.nz   <= m2_tag.nz;
    p_st.den      <= m2_den;
    for (int a = 0; a < 3; a++) begin
      p_st.tag.sat[a] <= DenW'(ks[a]) >= m2_den;
      p_st.rem[a]     <= (DenW'(ks[a]) >= m2_den) ? '0 : DenW'(ks[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ks[a] = {m2_tag.k[a], 11'd0};
    end
  end

  assign dv_st[0] = p_st;

  for (genvar g = 0; g < QuoW; g++) begin : g_div
    dnb_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (dv_vld[g]),
      .in_st   (dv_st[g]),
      .out_vld (dv_vld[g+1]),
      .out_st  (dv_st[g+1])
    );
  end

  // accumulation
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      term[a] = dv_st[QuoW].tag.sat[a] ? TERM_LIM : SumW'(dv_st[QuoW].quo[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld[QuoW] && dv_st[QuoW].tag.last;
    end
    if (state == S_IDLE && req_acc) begin
      acc     <= '0;
      sat_acc <= 1'b0;
    end else if (dv_vld[QuoW] && dv_st[QuoW].tag.on) begin
      for (int a = 0; a < 3; a++) begin
        if (dv_st[QuoW].tag.nz[a]) begin
          acc[a] <= dv_st[QuoW].tag.neg[a] ? acc[a] + term[a] : acc[a] - term[a];
        end
      end
      sat_acc <= sat_acc | (|(dv_st[QuoW].tag.sat & dv_st[QuoW].tag.nz));
    end
  end

  // final clamp and result register
  always_comb begin
    clamp_sat = sat_acc;
    for (int a = 0; a < 3; a++) begin
      if ($signed(acc[a]) > $signed(ACC_HI)) begin
        clamp_acc[a] = ACC_HI[AccW-1:0];
        clamp_sat    = 1'b1;
      end else if ($signed(acc[a]) < $signed(ACC_LO)) begin
        clamp_acc[a] = ACC_LO[AccW-1:0];
        clamp_sat    = 1'b1;
      end else begin
        clamp_acc[a] = acc[a][AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (state == S_FIN && (!rsp_vld || rsp.ready)) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
    if (state == S_FIN && (!rsp_vld || rsp.ready)) begin
      out_acc <= clamp_acc;
      out_sat <= clamp_sat;
    end
  end

  assign rsp.valid     = rsp_vld;
  assign rsp.acc_x     = out_acc[0];
  assign rsp.acc_y     = out_acc[1];
  assign rsp.acc_z     = out_acc[2];
  assign rsp.saturated = out_sat;

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done_q |-> state == S_DRAIN)
    else $error("pipeline end marker outside drain");

  a_eval_fetch: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == OP_EVAL) |=> state == S_FETCH)
    else $error("evaluate request did not start a fetch");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (!s0_vld && !dv_vld[QuoW] && !sq_vld[RootW]))
    else $error("pair pipeline busy while idle");

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!rsp_vld || rsp.ready)) |=> (rsp_vld && state == S_IDLE))
    else $error("result not posted on finish");

endmodule

// ===== verif/direct_nbody_acceleration_test.sv =====
// Self-checking testbench for the direct N-body acceleration block.
`timescale 1ns / 100ps

module direct_nbody_acceleration_test;
  import dnb_pkg::*;

  localparam int SLOTS = 4096;
  localparam int IDLE_WAIT = 200;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int LONG_HOLD = 600;
  localparam logic [23:0] FULL = 24'hFFFFFF;

  typedef struct {
    logic        op;
    logic [11:0] slot;
    logic [23:0] x, y, z, m;
  } request_t;

  typedef struct {
    logic [AccW-1:0] ax, ay, az;
    logic            sat;
  } accel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_COUNT;
  logic [CfgW-1:0] cfg_data = '0;

  dnb_req_if req ();
  dnb_rsp_if rsp ();

  direct_nbody_acceleration uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always #1 clk = ~clk;

  logic [23:0] store_x [SLOTS];
  logic [23:0] store_y [SLOTS];
  logic [23:0] store_z [SLOTS];
  logic [23:0] store_m [SLOTS];
  logic [12:0] model_count;
  logic [23:0] model_soft;

  request_t pending_reqs[$];
  accel_t   expected_accels[$];
  request_t cur_req;
  int burst_left = 0;
  int gap_left = 0;
  int mismatches = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;
  int rand_reqs = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic accel_t softened_accel(input logic [11:0] self);
    accel_t res;
    longint sum [3];
    longint d [3];
    logic [63:0] r2, root, mag, k;
    logic [127:0] den, q;
    int n;
    res.sat = 1'b0;
    for (int a = 0; a < 3; a++) sum[a] = 0;
    n = (model_count > SLOTS) ? SLOTS : model_count;
    for (int j = 0; j < n; j++) begin
      if (j == self) continue;
      d[0] = longint'({40'd0, store_x[self]}) - longint'({40'd0, store_x[j]});
      d[1] = longint'({40'd0, store_y[self]}) - longint'({40'd0, store_y[j]});
      d[2] = longint'({40'd0, store_z[self]}) - longint'({40'd0, store_z[j]});
      r2 = {32'd0, model_soft, 8'd0};
      for (int a = 0; a < 3; a++) r2 += d[a] * d[a];
      if (r2 == 0) continue;
      root = int_sqrt(r2 << 12);
      den = {64'd0, r2} * {64'd0, root};
      for (int a = 0; a < 3; a++) begin
        if (d[a] == 0) continue;
        mag = (d[a] < 0) ? -d[a] : d[a];
        k = {40'd0, store_m[j]} * mag;
        q = ({64'd0, k} << 58) / den;
        if (q >= (128'd1 << 47)) begin
          q = 128'd1 << 47;
          res.sat = 1'b1;
        end
        if (d[a] > 0) sum[a] -= longint'(q[63:0]);
        else sum[a] += longint'(q[63:0]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      if (sum[a] > (64'sd1 <<< 47) - 1) begin
        sum[a] = (64'sd1 <<< 47) - 1;
        res.sat = 1'b1;
      end else if (sum[a] < -(64'sd1 <<< 47)) begin
        sum[a] = -(64'sd1 <<< 47);
        res.sat = 1'b1;
      end
    end
    res.ax = sum[0][AccW-1:0];
    res.ay = sum[1][AccW-1:0];
    res.az = sum[2][AccW-1:0];
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.operation <= OP_LOAD;
      req.slot <= '0;
      req.pos_x <= '0;
      req.pos_y <= '0;
      req.pos_z <= '0;
      req.mass <= '0;
    end else begin
      if (req.valid && req.ready) begin
        if (cur_req.op == OP_LOAD) begin
          store_x[cur_req.slot] = cur_req.x;
          store_y[cur_req.slot] = cur_req.y;
          store_z[cur_req.slot] = cur_req.z;
          store_m[cur_req.slot] = cur_req.m;
        end else begin
          expected_accels.push_back(softened_accel(cur_req.slot));
        end
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.operation <= cur_req.op;
          req.slot <= cur_req.slot;
          req.pos_x <= cur_req.x;
          req.pos_y <= cur_req.y;
          req.pos_z <= cur_req.z;
          req.mass <= cur_req.m;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    accel_t exp_a;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_accels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h sat=%b",
                                         rsp.acc_x, rsp.acc_y, rsp.acc_z, rsp.saturated);
        end else begin
          exp_a = expected_accels.pop_front();
          if (rsp.acc_x !== exp_a.ax || rsp.acc_y !== exp_a.ay ||
              rsp.acc_z !== exp_a.az || rsp.saturated !== exp_a.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                       exp_a.ax, exp_a.ay, exp_a.az, exp_a.sat,
                       rsp.acc_x, rsp.acc_y, rsp.acc_z, rsp.saturated);
          end
        end
      end
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 3) != 0);
          default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_write)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic push_req(input logic op, input logic [11:0] slot, input logic [23:0] x,
                          input logic [23:0] y, input logic [23:0] z, input logic [23:0] m);
    request_t r;
    r.op = op;
    r.slot = slot;
    r.x = x;
    r.y = y;
    r.z = z;
    r.m = m;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req.valid || expected_accels.size() != 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_COUNT) model_count = val[12:0];
    else model_soft = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [23:0] near(input logic [23:0] base);
    case ($urandom_range(0, 3))
      0: return 24'(base + $urandom_range(0, 15));
      1: return base ^ (24'd1 << $urandom_range(0, 23));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] bx, by, bz;
    int n;
    model_count = COUNT_RESET;
    model_soft = SOFT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_COUNT, 24'd48);
    push_req(OP_LOAD, 12'd0, '0, '0, '0, FULL);
    push_req(OP_LOAD, 12'd4095, FULL, FULL, FULL, FULL);
    for (int s = 1; s < 48; s++)
      push_req(OP_LOAD, 12'(s), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    push_req(OP_EVAL, 12'd0, '0, '0, '0, '0);
    push_req(OP_EVAL, 12'd4095, FULL, FULL, FULL, FULL);
    push_req(OP_EVAL, 12'd47, '0, '0, '0, '0);
    drain();

    write_reg(REG_COUNT, 24'd8);
    write_reg(REG_SOFT, 24'd0);
    push_req(OP_LOAD, 12'd0, '0, '0, '0, FULL);
    push_req(OP_LOAD, 12'd1, FULL, FULL, FULL, FULL);
    push_req(OP_LOAD, 12'd2, 24'd100, 24'd200, 24'd300, FULL);
    push_req(OP_LOAD, 12'd3, 24'd100, 24'd200, 24'd300, 24'd1);
    push_req(OP_LOAD, 12'd4, 24'd101, 24'd200, 24'd300, FULL);
    push_req(OP_LOAD, 12'd5, '0, FULL, '0, '0);
    push_req(OP_LOAD, 12'd6, FULL, '0, FULL, 24'd1);
    push_req(OP_LOAD, 12'd7, 24'h123456, 24'hABCDEF, 24'h555555, 24'hAAAAAA);
    for (int s = 0; s < 8; s++) push_req(OP_EVAL, 12'(s), FULL, '0, FULL, FULL);
    drain();

    write_reg(REG_SOFT, FULL);
    push_req(OP_EVAL, 12'd2, '0, '0, '0, '0);
    push_req(OP_EVAL, 12'd0, '0, '0, '0, '0);
    drain();
    write_reg(REG_COUNT, 24'd0);
    push_req(OP_EVAL, 12'd3, '0, '0, '0, '0);
    drain();
    write_reg(REG_COUNT, 24'd1);
    push_req(OP_EVAL, 12'd0, '0, '0, '0, '0);
    push_req(OP_EVAL, 12'd5, '0, '0, '0, '0);
    drain();
    write_reg(REG_COUNT, 24'd48);
    write_reg(REG_SOFT, SOFT_RESET);
    push_req(OP_EVAL, 12'd4, '0, '0, '0, '0);
    drain();

    while (rand_reqs < 60) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_SOFT, 24'd0);
        1: write_reg(REG_SOFT, FULL);
        2: write_reg(REG_SOFT, SOFT_RESET);
        default: write_reg(REG_SOFT, 24'($urandom_range(0, 4095)));
      endcase
      write_reg(REG_COUNT, 24'($urandom_range(1, 48)));
      if (rand_reqs == 0 || $urandom_range(0, 2) == 0) hold_asked++;
      bx = 24'($urandom);
      by = 24'($urandom);
      bz = 24'($urandom);
      n = $urandom_range(12, 24);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 6) begin
          push_req(OP_LOAD, ($urandom_range(0, 4) == 0) ? 12'($urandom) :
                   12'($urandom_range(0, model_count - 1)),
                   near(bx), near(by), near(bz), 24'($urandom));
        end else begin
          push_req(OP_EVAL, ($urandom_range(0, 3) == 0) ? 12'd4095 :
                   12'($urandom_range(0, model_count - 1)),
                   24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        end
        rand_reqs++;
      end
      drain();
    end

    if (mismatches == 0 && expected_accels.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
